// ===== rtl/prfd_pkg.sv =====
// Package for the PPM radio frame decoder.
// Holds field widths, reset values, command and register codes, and the shared structs.
// No dependencies.
`default_nettype none

package prfd_pkg;

	localparam int KIND_W     = 2;
	localparam int TIME_W     = 16;
	localparam int CH_W       = 3;
	localparam int VAL_W      = 15;
	localparam int WIDTH_W    = 13;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam int CHANNELS_DEF = 8;

	localparam logic [KIND_W-1:0] KIND_CAPTURE  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_READ     = 2'd1;
	localparam logic [KIND_W-1:0] KIND_OVERRIDE = 2'd2;
	localparam logic [KIND_W-1:0] KIND_CLEAR    = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_TIMER_PERIOD   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_THRESHOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSE      = 2'd3;

	localparam logic [TIME_W-1:0]  TIMER_PERIOD_RST   = 16'd40000;
	localparam logic [TIME_W-1:0]  SYNC_THRESHOLD_RST = 16'd8000;
	localparam logic [VAL_W-1:0]   MIN_PULSE_RST      = 15'd900;
	localparam logic [VAL_W-1:0]   MAX_PULSE_RST      = 15'd2100;
	localparam logic [WIDTH_W-1:0] WIDTH_RST          = 13'd2400;
	localparam logic [WIDTH_W-1:0] WIDTH_MAX          = 13'd8191;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [TIME_W-1:0] capture_time;
		logic [CH_W-1:0]   channel;
		logic [VAL_W-1:0]  override_value;
	} item_t;

	typedef struct packed {
		logic [VAL_W-1:0] read_value;
		logic             frame_ready;
		logic             override_active;
	} result_t;

	typedef struct packed {
		logic [TIME_W-1:0] timer_period;
		logic [TIME_W-1:0] sync_threshold;
		logic [VAL_W-1:0]  min_pulse;
		logic [VAL_W-1:0]  max_pulse;
	} cfg_t;

endpackage

`default_nettype wire

// ===== rtl/ppm_radio_frame_decoder.sv =====
// Top level of the PPM radio frame decoder: input register, decode core and result register.
// An accepted input transaction passes the input register, then the result register.
// Throughput is one transaction per cycle while the result register is freed on out_ready.
// Reset clears the pipeline, the slot count, the ready flag, the overrides and the capture
// timestamp, loads every channel width with 2400 and restores the register defaults.
// Depends on prfd_pkg, prfd_cfg_regs, prfd_in_reg and prfd_core.
`default_nettype none

module ppm_radio_frame_decoder #(
	parameter int CHANNELS = prfd_pkg::CHANNELS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [prfd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [prfd_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [prfd_pkg::KIND_W-1:0]      kind,
	input  wire logic [prfd_pkg::TIME_W-1:0]      capture_time,
	input  wire logic [prfd_pkg::CH_W-1:0]        channel,
	input  wire logic [prfd_pkg::VAL_W-1:0]       override_value,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [prfd_pkg::VAL_W-1:0]            read_value,
	output logic                                  frame_ready,
	output logic                                  override_active
);

	prfd_pkg::cfg_t    cfg;
	prfd_pkg::item_t   item_s1;
	prfd_pkg::result_t result_d;
	prfd_pkg::result_t result_s2;
	logic              valid_s1;
	logic              valid_s2;
	logic              advance;

	assign advance = valid_s1 && (!valid_s2 || out_ready);

	prfd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	prfd_in_reg u_in (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.kind           (kind),
		.capture_time   (capture_time),
		.channel        (channel),
		.override_value (override_value),
		.advance        (advance),
		.valid_s1       (valid_s1),
		.item_s1        (item_s1)
	);

	prfd_core #(
		.CHANNELS (CHANNELS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.result  (result_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_d;
		end
	end

	assign out_valid       = valid_s2;
	assign read_value      = result_s2.read_value;
	assign frame_ready     = result_s2.frame_ready;
	assign override_active = result_s2.override_active;

endmodule

`default_nettype wire

// ===== rtl/prfd_cfg_regs.sv =====
// Configuration registers of the PPM radio frame decoder.
// Depends on prfd_pkg for register codes, widths and reset values.
`default_nettype none

module prfd_cfg_regs (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [prfd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [prfd_pkg::CFG_DATA_W-1:0]  cfg_data,
	output prfd_pkg::cfg_t                        cfg
);

	prfd_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timer_period   <= prfd_pkg::TIMER_PERIOD_RST;
			cfg_q.sync_threshold <= prfd_pkg::SYNC_THRESHOLD_RST;
			cfg_q.min_pulse      <= prfd_pkg::MIN_PULSE_RST;
			cfg_q.max_pulse      <= prfd_pkg::MAX_PULSE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				prfd_pkg::CFG_TIMER_PERIOD: begin
					cfg_q.timer_period <= prfd_pkg::TIME_W'(cfg_data);
				end
				prfd_pkg::CFG_SYNC_THRESHOLD: begin
					cfg_q.sync_threshold <= prfd_pkg::TIME_W'(cfg_data);
				end
				prfd_pkg::CFG_MIN_PULSE: begin
					cfg_q.min_pulse <= prfd_pkg::VAL_W'(cfg_data);
				end
				prfd_pkg::CFG_MAX_PULSE: begin
					cfg_q.max_pulse <= prfd_pkg::VAL_W'(cfg_data);
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/prfd_in_reg.sv =====
// Input register stage of the PPM radio frame decoder.
// Depends on prfd_pkg for the item struct and field widths.
`default_nettype none

module prfd_in_reg (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [prfd_pkg::KIND_W-1:0]    kind,
	input  wire logic [prfd_pkg::TIME_W-1:0]    capture_time,
	input  wire logic [prfd_pkg::CH_W-1:0]      channel,
	input  wire logic [prfd_pkg::VAL_W-1:0]     override_value,
	input  wire logic                           advance,
	output logic                                valid_s1,
	output prfd_pkg::item_t                     item_s1
);

	logic            valid_q;
	prfd_pkg::item_t item_q;

	assign in_ready = !valid_q || advance;
	assign valid_s1 = valid_q;
	assign item_s1  = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q.kind           <= kind;
			item_q.capture_time   <= capture_time;
			item_q.channel        <= channel;
			item_q.override_value <= override_value;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/prfd_core.sv =====
// Decode state and per-transaction logic of the PPM radio frame decoder.
// Holds the capture timestamp, slot count, channel widths, overrides and the ready flag.
// Depends on prfd_pkg for structs, codes, widths and reset values.
`default_nettype none

module prfd_core #(
	parameter int CHANNELS = prfd_pkg::CHANNELS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         advance,
	input  wire prfd_pkg::item_t item,
	input  wire prfd_pkg::cfg_t  cfg,
	output prfd_pkg::result_t result
);

	localparam int CNT_W    = $clog2(CHANNELS + 1);
	localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CMP_W    = (CNT_W > prfd_pkg::CH_W) ? CNT_W : prfd_pkg::CH_W;

	logic [prfd_pkg::TIME_W-1:0]  prev_q;
	logic [CNT_W-1:0]             slot_q;
	logic [prfd_pkg::WIDTH_W-1:0] width_q [CHANNELS];
	logic [prfd_pkg::VAL_W-1:0]   ovr_q [CHANNELS];
	logic                         flag_q;

	logic [IDX_W-1:0]             ch_idx;
	logic [IDX_W-1:0]             slot_idx;
	logic                         ch_ok;
	logic                         slot_open;
	logic [prfd_pkg::TIME_W-1:0]  interval;
	logic                         is_sync;
	logic [prfd_pkg::WIDTH_W-1:0] width_sat;
	logic [prfd_pkg::VAL_W-1:0]   half_width;
	logic [prfd_pkg::VAL_W-1:0]   clamped;
	logic [prfd_pkg::VAL_W-1:0]   ovr_sel;
	logic                         width_we;
	logic [CNT_W-1:0]             slot_d;
	logic                         flag_d;
	logic                         ovr_we;
	logic                         ovr_clr;
	logic [prfd_pkg::VAL_W-1:0]   read_d;
	logic                         any_d;

	always_comb begin
		ch_idx    = IDX_W'(item.channel);
		slot_idx  = IDX_W'(slot_q);
		ch_ok     = CMP_W'(item.channel) < CMP_W'(CHANNELS);
		slot_open = slot_q < CNT_W'(CHANNELS);

		if (item.capture_time < prev_q) begin
			interval = item.capture_time + cfg.timer_period - prev_q;
		end else begin
			interval = item.capture_time - prev_q;
		end
		is_sync = interval > cfg.sync_threshold;
		if (interval > prfd_pkg::TIME_W'(prfd_pkg::WIDTH_MAX)) begin
			width_sat = prfd_pkg::WIDTH_MAX;
		end else begin
			width_sat = prfd_pkg::WIDTH_W'(interval);
		end

		ovr_sel    = ch_ok ? ovr_q[ch_idx] : '0;
		half_width = ch_ok ? prfd_pkg::VAL_W'(width_q[ch_idx] >> 1) : '0;
		if (half_width < cfg.min_pulse) begin
			clamped = cfg.min_pulse;
		end else if (half_width > cfg.max_pulse) begin
			clamped = cfg.max_pulse;
		end else begin
			clamped = half_width;
		end

		width_we = 1'b0;
		slot_d   = slot_q;
		flag_d   = flag_q;
		ovr_we   = 1'b0;
		ovr_clr  = 1'b0;
		read_d   = '0;

		unique case (item.kind)
			prfd_pkg::KIND_CAPTURE: begin
				if (is_sync) begin
					slot_d = '0;
				end else if (slot_open) begin
					width_we = 1'b1;
					slot_d   = slot_q + CNT_W'(1);
					if (slot_d >= CNT_W'(CHANNELS)) begin
						flag_d = 1'b1;
					end
				end
			end
			prfd_pkg::KIND_READ: begin
				if (ch_ok) begin
					if (ovr_sel != '0) begin
						read_d = ovr_sel;
					end else begin
						read_d = clamped;
						flag_d = 1'b0;
					end
				end
			end
			prfd_pkg::KIND_OVERRIDE: begin
				if (ch_ok) begin
					ovr_we = 1'b1;
					flag_d = 1'b1;
				end
			end
			prfd_pkg::KIND_CLEAR: begin
				ovr_clr = 1'b1;
			end
			default: begin
			end
		endcase

		any_d = 1'b0;
		for (int i = 0; i < CHANNELS; i++) begin
			if (ovr_clr) begin
				any_d = any_d;
			end else if (ovr_we && (ch_idx == IDX_W'(i))) begin
				any_d = any_d || (item.override_value != '0);
			end else begin
				any_d = any_d || (ovr_q[i] != '0);
			end
		end

		result.read_value      = read_d;
		result.frame_ready     = flag_d;
		result.override_active = any_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			slot_q <= '0;
			flag_q <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				width_q[i] <= prfd_pkg::WIDTH_RST;
				ovr_q[i]   <= '0;
			end
		end else if (advance) begin
			slot_q <= slot_d;
			flag_q <= flag_d;
			if (item.kind == prfd_pkg::KIND_CAPTURE) begin
				prev_q <= item.capture_time;
			end
			if (width_we) begin
				width_q[slot_idx] <= width_sat;
			end
			if (ovr_clr) begin
				for (int i = 0; i < CHANNELS; i++) begin
					ovr_q[i] <= '0;
				end
			end else if (ovr_we) begin
				ovr_q[ch_idx] <= item.override_value;
			end
		end
	end

endmodule

`default_nettype wire
